/* rtl/cop_pkg.sv */
// Package for the OOK pulse decoder: payload words, config and phase types,
// symbol codes, frame patterns and the tolerance compare. No dependencies.
`default_nettype none
package cop_pkg;

	localparam int DUR_W   = 19;
	localparam int UNIT_W  = 12;
	localparam int TOL_W   = 11;
	localparam int MINS_W  = 5;
	localparam int CNT_W   = 6;
	localparam int KEY_W   = 9;
	localparam int NBITS_W = 4;
	localparam int CFG_W   = 12;
	localparam int ADDR_W  = 2;
	// Only the low eleven symbols are ever examined by the frame check.
	localparam int SHIFT_W = 44;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [3:0] SYM_STOP = 4'b0001;
	localparam logic [3:0] SYM_ONE  = 4'b0011;
	localparam logic [3:0] SYM_ZERO = 4'b0111;

	localparam logic [SHIFT_W-1:0] PAT7_MASK = 44'hF000000FF0F;
	localparam logic [SHIFT_W-1:0] PAT7_VAL  = 44'h10000001101;
	localparam logic [SHIFT_W-1:0] PAT8_MASK = 44'h0F00000F00F;
	localparam logic [SHIFT_W-1:0] PAT8_VAL  = 44'h01000001001;
	localparam logic [SHIFT_W-1:0] PAT9_MASK = 44'hF000000000F;
	localparam logic [SHIFT_W-1:0] PAT9_VAL  = 44'h10000000001;

	localparam logic [NBITS_W-1:0] NBITS_7 = 4'd7;
	localparam logic [NBITS_W-1:0] NBITS_8 = 4'd8;
	localparam logic [NBITS_W-1:0] NBITS_9 = 4'd9;

	localparam logic [DUR_W-1:0] SYNC_UNITS = 19'd39;
	localparam logic [DUR_W-1:0] SYNC_TOLS  = 19'd20;
	localparam logic [DUR_W-1:0] END_UNITS  = 19'd5;

	typedef enum logic [ADDR_W-1:0] {
		REG_UNIT_TIME   = 2'd0,
		REG_TOLERANCE   = 2'd1,
		REG_MIN_SYMBOLS = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_START = 2'd1,
		PH_GAP   = 2'd2,
		PH_HIGH  = 2'd3
	} phase_t;

	typedef struct packed {
		logic             pulse_level;
		logic [DUR_W-1:0] pulse_duration;
	} pulse_t;

	typedef struct packed {
		logic [KEY_W-1:0]   decoded_key;
		logic [NBITS_W-1:0] key_bits;
	} key_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit_time;
		logic [TOL_W-1:0]  tolerance;
	} timing_t;

	typedef struct packed {
		logic frame_end;
	} cls_stat_t;

	// |d - nom| < tol
	function automatic logic near_to(input logic [DUR_W-1:0] d,
			input logic [DUR_W-1:0] nom, input logic [DUR_W-1:0] tol);
		logic [DUR_W-1:0] diff;
		diff = (d > nom) ? (d - nom) : (nom - d);
		return diff < tol;
	endfunction

endpackage
`default_nettype wire

/* rtl/cop_classify.sv */
// Pulse classifier: phase FSM, symbol shift register, symbol count, last gap.
// Depends on cop_pkg.
`default_nettype none
module cop_classify
	import cop_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire pulse_t               pulse,
	input  wire timing_t              timing,
	output cls_stat_t                 stat,
	output logic      [SHIFT_W-1:0]   shift,
	output logic      [CNT_W-1:0]     count
);

	phase_t             phase_q, phase_d;
	logic [SHIFT_W-1:0] shift_q;
	logic [CNT_W-1:0]   count_q;
	logic [DUR_W-1:0]   last_gap_q;

	logic [DUR_W-1:0] u1, u2, u3, u5, u39, t1, t20, d;
	logic             hi, m_sync, m_start, m_end;
	logic             m_stop, m_one, m_zero;

	// action flags
	logic             do_push, do_clear, do_save;
	logic [3:0]       sym;

	always_comb begin
		d      = pulse.pulse_duration;
		hi     = pulse.pulse_level;
		u1     = DUR_W'(timing.unit_time);
		u2     = u1 << 1;
		u3     = u2 + u1;
		u5     = u1 * END_UNITS;
		u39    = u1 * SYNC_UNITS;
		t1     = DUR_W'(timing.tolerance);
		t20    = t1 * SYNC_TOLS;
		m_sync  = near_to(d, u39, t20);
		m_start = near_to(d, u1, t1);
		m_end   = d > u5;
		m_stop  = near_to(last_gap_q, u3, t1) && near_to(d, u1, t1);
		m_one   = near_to(last_gap_q, u2, t1) && near_to(d, u2, t1);
		m_zero  = near_to(last_gap_q, u1, t1) && near_to(d, u3, t1);
	end

	// next phase
	always_comb begin
		unique case (phase_q)
			PH_HUNT:  phase_d = (!hi && m_sync) ? PH_START : PH_HUNT;
			PH_START: phase_d = (hi && m_start) ? PH_GAP : PH_HUNT;
			PH_GAP:   phase_d = (hi || m_end) ? PH_HUNT : PH_HIGH;
			PH_HIGH:  phase_d = (hi && (m_stop || m_one || m_zero)) ? PH_GAP : PH_HUNT;
			default:  phase_d = PH_HUNT;
		endcase
	end

	// actions
	always_comb begin
		do_push        = 1'b0;
		do_clear       = 1'b0;
		do_save        = 1'b0;
		stat.frame_end = 1'b0;
		sym            = SYM_STOP;
		unique case (phase_q)
			PH_START: begin
				do_clear = hi && m_start;
				do_push  = hi && m_start;
			end
			PH_GAP: begin
				stat.frame_end = !hi && m_end;
				do_save        = !hi && !m_end;
			end
			PH_HIGH: begin
				do_push = hi && (m_stop || m_one || m_zero);
				priority if (m_stop) sym = SYM_STOP;
				else if (m_one)      sym = SYM_ONE;
				else                 sym = SYM_ZERO;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			shift_q    <= '0;
			count_q    <= '0;
			last_gap_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (do_save)
				last_gap_q <= d;
			if (do_push) begin
				if (do_clear) begin
					shift_q <= SHIFT_W'(sym);
					count_q <= CNT_W'(1);
				end else begin
					shift_q <= {shift_q[SHIFT_W-5:0], sym};
					if (count_q != CNT_MAX)
						count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	assign shift = shift_q;
	assign count = count_q;

endmodule
`default_nettype wire

/* rtl/cop_frame_decode.sv */
// Frame check: symbol count, pattern match and nibble-to-key decode.
// Depends on cop_pkg.
`default_nettype none
module cop_frame_decode
	import cop_pkg::*;
(
	input  wire logic [SHIFT_W-1:0] shift,
	input  wire logic [CNT_W-1:0]   count,
	input  wire logic [MINS_W-1:0]  min_symbols,
	output logic                    hit,
	output key_t                    key
);

	logic [SHIFT_W-1:0] s, nib;
	logic [NBITS_W-1:0] n;
	logic [KEY_W-1:0]   k;
	logic               matched, ok;
	logic [3:0]         c;

	always_comb begin
		matched = 1'b1;
		n       = NBITS_9;
		s       = shift;
		nib     = '0;
		priority if ((shift & PAT7_MASK) == PAT7_VAL) begin
			n   = NBITS_7;
			s   = shift & ~PAT7_MASK;
			nib = (s >> 12) | ((s >> 4) & SHIFT_W'(4'hF));
		end else if ((shift & PAT8_MASK) == PAT8_VAL) begin
			n   = NBITS_8;
			s   = shift & ~PAT8_MASK;
			nib = (s >> 4) | (SHIFT_W'(SYM_ZERO) << 8);
		end else if ((shift & PAT9_MASK) == PAT9_VAL) begin
			n   = NBITS_9;
			s   = shift & ~PAT9_MASK;
			nib = s >> 4;
		end else begin
			matched = 1'b0;
		end

		// nine independent nibble checks
		ok = 1'b1;
		k  = '0;
		for (int i = 0; i < KEY_W; i++) begin
			c = nib[4*i +: 4];
			if (NBITS_W'(i) < n) begin
				if (c == SYM_ONE)
					k[i] = 1'b1;
				else if (c != SYM_ZERO)
					ok = 1'b0;
			end
		end

		hit             = matched && ok && (count >= CNT_W'(min_symbols));
		key.decoded_key = k;
		key.key_bits    = n;
	end

endmodule
`default_nettype wire

/* rtl/chamberlain_ook_pulse_decoder.sv */
// OOK pulse decoder, top level. Depends on cop_pkg, cop_classify, cop_frame_decode.
// Path: the frame-ending gap is held in the input register, and the key word is then
// loaded into the result register once that register can take a new word (input, result reg).
// Throughput: one pulse word per cycle unless a full result register waits on out_ready;
// the single pass through the phase logic sits between the input register and the result register.
// Reset (arst_n low, asynchronous): hunting for sync, registers at defaults.
`default_nettype none
module chamberlain_ook_pulse_decoder
	import cop_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// pulse words in
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pulse_t            in_data,
	// key words out
	output logic                   out_valid,
	input  wire logic              out_ready,
	output key_t                   out_data,
	// configuration writes
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]  cfg_wdata
);

	// configuration registers
	logic [UNIT_W-1:0] unit_time_q;
	logic [TOL_W-1:0]  tolerance_q;
	logic [MINS_W-1:0] min_symbols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_time_q   <= UNIT_W'(1000);
			tolerance_q   <= TOL_W'(200);
			min_symbols_q <= MINS_W'(10);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_UNIT_TIME:   unit_time_q   <= cfg_wdata[UNIT_W-1:0];
				REG_TOLERANCE:   tolerance_q   <= cfg_wdata[TOL_W-1:0];
				REG_MIN_SYMBOLS: min_symbols_q <= cfg_wdata[MINS_W-1:0];
				default: ;
			endcase
		end
	end

	// input register: the word is processed while it sits here, and the
	// stage drains whenever the result register can take a new word
	logic   in_valid_s1;
	pulse_t in_s1;
	logic   out_free, advance;

	assign out_free = !out_valid || out_ready;
	assign advance  = in_valid_s1 && out_free;
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (in_ready)
			in_valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_s1 <= in_data;
	end

	// phase machine and symbol store
	timing_t            timing;
	cls_stat_t          stat;
	logic [SHIFT_W-1:0] shift;
	logic [CNT_W-1:0]   count;

	assign timing.unit_time = unit_time_q;
	assign timing.tolerance = tolerance_q;

	cop_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.pulse  (in_s1),
		.timing (timing),
		.stat   (stat),
		.shift  (shift),
		.count  (count)
	);

	// frame check runs on the stored symbols; used only on a frame end
	logic hit;
	key_t key;

	cop_frame_decode u_frame_decode (
		.shift       (shift),
		.count       (count),
		.min_symbols (min_symbols_q),
		.hit         (hit),
		.key         (key)
	);

	// result register
	logic res_valid_q;
	key_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_free)
			res_valid_q <= advance && stat.frame_end && hit;
	end

	always_ff @(posedge clk) begin
		if (advance && stat.frame_end && hit)
			res_q <= key;
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule
`default_nettype wire
